// ===== rtl/gaq_pkg.sv =====
// ----------------------------------------------------------------------------
// gaq_pkg: shared definitions of the gamma-2 colour quantizer
// Widths, step counts, register codes and the records passed between the
// configuration block, the channel lanes and the merging output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package gaq_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int COUNT_WIDTH   = 16;
	localparam int QUOT_WIDTH    = 16;
	localparam int ROOT_WIDTH    = 8;
	localparam int BYTE_WIDTH    = 8;

	localparam int DIV_STEPS   = QUOT_WIDTH;
	localparam int ROOT_STEPS  = ROOT_WIDTH;
	localparam int LANE_STAGES = 1 + DIV_STEPS + ROOT_STEPS;
	localparam int LANES       = 3;

	localparam int LANE_RED   = 0;
	localparam int LANE_GREEN = 1;
	localparam int LANE_BLUE  = 2;

	localparam logic [BYTE_WIDTH-1:0]  BYTE_MAX           = '1;
	localparam logic [COUNT_WIDTH-1:0] SAMPLE_COUNT_RESET = COUNT_WIDTH'(1);

	localparam int APB_DATA_WIDTH  = 32;
	localparam int APB_ADDR_WIDTH  = 3;
	localparam int REG_INDEX_WIDTH = APB_ADDR_WIDTH - 2;

	localparam logic [REG_INDEX_WIDTH-1:0] REG_SAMPLE_COUNT = '0;

	typedef struct packed {
		logic                   advance;
		logic [COUNT_WIDTH-1:0] sample_count;
	} gaq_ctrl_t;

	typedef struct packed {
		logic                  ovf;
		logic [ROOT_WIDTH-1:0] root;
	} gaq_lane_res_t;

endpackage

`default_nettype wire

// ===== rtl/gaq_if.sv =====
// ----------------------------------------------------------------------------
// gaq_if: pixel channels of the gamma-2 colour quantizer
// Valid/ready channels for the accumulated sums going in and the quantized
// bytes coming out.
// ----------------------------------------------------------------------------
`default_nettype none

interface gaq_pixel_in_if #(
	parameter int SUM_WIDTH = 32
);
	logic                 valid;
	logic                 ready;
	logic [SUM_WIDTH-1:0] red_sum;
	logic [SUM_WIDTH-1:0] green_sum;
	logic [SUM_WIDTH-1:0] blue_sum;

	modport source (output valid, output red_sum, output green_sum, output blue_sum,
		input ready);
	modport sink (input valid, input red_sum, input green_sum, input blue_sum,
		output ready);
endinterface

interface gaq_pixel_out_if;
	logic                           valid;
	logic                           ready;
	logic [gaq_pkg::BYTE_WIDTH-1:0] red_byte;
	logic [gaq_pkg::BYTE_WIDTH-1:0] green_byte;
	logic [gaq_pkg::BYTE_WIDTH-1:0] blue_byte;

	modport source (output valid, output red_byte, output green_byte, output blue_byte,
		input ready);
	modport sink (input valid, input red_byte, input green_byte, input blue_byte,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/gaq_apb_regs.sv =====
// ----------------------------------------------------------------------------
// gaq_apb_regs: configuration register block
// Holds the sample count behind a simple APB-style port with no wait states.
// ----------------------------------------------------------------------------
`default_nettype none

module gaq_apb_regs (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [gaq_pkg::APB_ADDR_WIDTH-1:0]   paddr,
	input  wire logic [gaq_pkg::APB_DATA_WIDTH-1:0]   pwdata,
	output logic      [gaq_pkg::APB_DATA_WIDTH-1:0]   prdata,
	output logic                                      pready,
	output logic      [gaq_pkg::COUNT_WIDTH-1:0]      sample_count
);
	import gaq_pkg::*;

	logic [REG_INDEX_WIDTH-1:0] reg_index;
	logic                       wr_en;
	logic [COUNT_WIDTH-1:0]     sample_count_q;

	assign reg_index    = paddr[APB_ADDR_WIDTH-1:2];
	assign wr_en        = psel && penable && pwrite;
	assign pready       = 1'b1;
	assign sample_count = sample_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_COUNT_RESET;
		end else if (wr_en && (reg_index == REG_SAMPLE_COUNT)) begin
			sample_count_q <= pwdata[COUNT_WIDTH-1:0];
		end
	end

	always_comb begin
		if (reg_index == REG_SAMPLE_COUNT) begin
			prdata = APB_DATA_WIDTH'(sample_count_q);
		end else begin
			prdata = '0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gaq_lane.sv =====
// ----------------------------------------------------------------------------
// gaq_lane: one colour channel of the quantizer
// A pipelined restoring divider giving one quotient bit per stage, followed
// by a pipelined square root giving one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gaq_lane #(
	parameter int SUM_WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire gaq_pkg::gaq_ctrl_t      ctrl,
	input  wire logic [SUM_WIDTH-1:0]    sum,
	output gaq_pkg::gaq_lane_res_t       res
);
	import gaq_pkg::*;

	localparam int HI_WIDTH  = SUM_WIDTH - FRACTION_BITS;
	localparam int CMP_WIDTH = (HI_WIDTH > COUNT_WIDTH) ? HI_WIDTH : COUNT_WIDTH;

	logic [HI_WIDTH-1:0]    sum_hi;
	logic [CMP_WIDTH-1:0]   hi_ext;
	logic [CMP_WIDTH-1:0]   count_ext;
	logic                   ovf_in;

	logic [COUNT_WIDTH-1:0] drem_s  [DIV_STEPS+1];
	logic [QUOT_WIDTH-1:0]  dword_s [DIV_STEPS+1];
	logic                   dovf_s  [DIV_STEPS+1];

	logic [COUNT_WIDTH:0]   dtrial   [DIV_STEPS];
	logic [COUNT_WIDTH:0]   ddiff    [DIV_STEPS];
	logic                   dtake    [DIV_STEPS];
	logic [COUNT_WIDTH-1:0] drem_nx  [DIV_STEPS];
	logic [QUOT_WIDTH-1:0]  dword_nx [DIV_STEPS];

	logic [ROOT_WIDTH-1:0]   sroot_s [ROOT_STEPS];
	logic [QUOT_WIDTH-1:0]   sval_s  [ROOT_STEPS];
	logic                    sovf_s  [ROOT_STEPS];

	logic [ROOT_WIDTH-1:0]   sroot_in [ROOT_STEPS];
	logic [QUOT_WIDTH-1:0]   sval_in  [ROOT_STEPS];
	logic                    sovf_in  [ROOT_STEPS];
	logic [ROOT_WIDTH-1:0]   strial   [ROOT_STEPS];
	logic [2*ROOT_WIDTH-1:0] ssquare  [ROOT_STEPS];
	logic [ROOT_WIDTH-1:0]   sroot_nx [ROOT_STEPS];

	// The quotient overflows 16 bits exactly when the integer part of the sum
	// reaches the count; otherwise that integer part is the first remainder.
	assign sum_hi    = sum[SUM_WIDTH-1:FRACTION_BITS];
	assign hi_ext    = CMP_WIDTH'(sum_hi);
	assign count_ext = CMP_WIDTH'(ctrl.sample_count);
	assign ovf_in    = (hi_ext >= count_ext);

	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			dtrial[k]   = {drem_s[k], dword_s[k][QUOT_WIDTH-1]};
			dtake[k]    = (dtrial[k] >= {1'b0, ctrl.sample_count});
			ddiff[k]    = dtrial[k] - {1'b0, ctrl.sample_count};
			drem_nx[k]  = dtake[k] ? ddiff[k][COUNT_WIDTH-1:0] : dtrial[k][COUNT_WIDTH-1:0];
			dword_nx[k] = {dword_s[k][QUOT_WIDTH-2:0], dtake[k]};
		end
	end

	always_comb begin
		for (int j = 0; j < ROOT_STEPS; j++) begin
			if (j == 0) begin
				sroot_in[j] = '0;
				sval_in[j]  = dword_s[DIV_STEPS];
				sovf_in[j]  = dovf_s[DIV_STEPS];
			end else begin
				sroot_in[j] = sroot_s[j-1];
				sval_in[j]  = sval_s[j-1];
				sovf_in[j]  = sovf_s[j-1];
			end
			strial[j]   = sroot_in[j] | (ROOT_WIDTH'(1) << (ROOT_WIDTH - 1 - j));
			ssquare[j]  = strial[j] * strial[j];
			sroot_nx[j] = (ssquare[j] <= sval_in[j]) ? strial[j] : sroot_in[j];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			drem_s[0]  <= hi_ext[COUNT_WIDTH-1:0];
			dword_s[0] <= sum[FRACTION_BITS-1:0];
			dovf_s[0]  <= ovf_in;
			for (int k = 0; k < DIV_STEPS; k++) begin
				drem_s[k+1]  <= drem_nx[k];
				dword_s[k+1] <= dword_nx[k];
				dovf_s[k+1]  <= dovf_s[k];
			end
			for (int j = 0; j < ROOT_STEPS; j++) begin
				sroot_s[j] <= sroot_nx[j];
				sval_s[j]  <= sval_in[j];
				sovf_s[j]  <= sovf_in[j];
			end
		end
	end

	assign res.ovf  = sovf_s[ROOT_STEPS-1];
	assign res.root = sroot_s[ROOT_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/gaq_merge.sv =====
// ----------------------------------------------------------------------------
// gaq_merge: output stage of the quantizer
// Saturates each lane's root and gathers the three channels into one
// registered output item.
// ----------------------------------------------------------------------------
`default_nettype none

module gaq_merge (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,
	input  wire logic                   lane_valid,
	input  wire gaq_pkg::gaq_lane_res_t lane_res [gaq_pkg::LANES],
	gaq_pixel_out_if.source             pixel_out
);
	import gaq_pkg::*;

	logic                  valid_q;
	logic [BYTE_WIDTH-1:0] byte_q  [LANES];
	logic [BYTE_WIDTH-1:0] byte_nx [LANES];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			byte_nx[i] = lane_res[i].ovf ? BYTE_MAX : BYTE_WIDTH'(lane_res[i].root);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= lane_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < LANES; i++) begin
				byte_q[i] <= byte_nx[i];
			end
		end
	end

	assign pixel_out.valid      = valid_q;
	assign pixel_out.red_byte   = byte_q[LANE_RED];
	assign pixel_out.green_byte = byte_q[LANE_GREEN];
	assign pixel_out.blue_byte  = byte_q[LANE_BLUE];

endmodule

`default_nettype wire

// ===== rtl/gamma2_average_color_quantizer_top.sv =====
// ----------------------------------------------------------------------------
// gamma2_average_color_quantizer_top: gamma-2 colour quantizer
// Turns three accumulated channel sums into three gamma corrected bytes.
// ----------------------------------------------------------------------------
// Usage:
// An item enters on pixel_in as three sums with 16 fraction bits and leaves
// on pixel_out as three bytes, each min(isqrt(sum / sample_count), 255).
// Three identical lanes work on the channels side by side; each lane divides
// with one quotient bit per pipeline stage and then takes the square root
// with one result bit per stage, and a merging stage registers the bytes.
// One item is taken every cycle while the receiver does not stall. An item
// accepted on pixel_in passes through the input stage, the 16 divider stages,
// the 8 root stages and the output register before it is shown on pixel_out.
// When the receiver stalls, the whole pipeline holds and pixel_in.ready
// falls; it stays high while the output register is empty or being taken.
// The user must write sample_count over the APB port only while no item is in
// flight; the block itself does not enforce it. Reset empties the pipeline and
// sets sample_count to one. A count of zero gives 255 on every channel.
// ----------------------------------------------------------------------------
`default_nettype none

module gamma2_average_color_quantizer_top #(
	parameter int SUM_WIDTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	gaq_pixel_in_if.sink                              pixel_in,
	gaq_pixel_out_if.source                           pixel_out,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [gaq_pkg::APB_ADDR_WIDTH-1:0]   paddr,
	input  wire logic [gaq_pkg::APB_DATA_WIDTH-1:0]   pwdata,
	output logic      [gaq_pkg::APB_DATA_WIDTH-1:0]   prdata,
	output logic                                      pready
);
	import gaq_pkg::*;

	localparam int LastStage = LANE_STAGES - 1;

	logic                   adv;
	logic [COUNT_WIDTH-1:0] sample_count;
	gaq_ctrl_t              ctrl;
	logic [SUM_WIDTH-1:0]   lane_sum [LANES];
	gaq_lane_res_t          lane_res [LANES];
	logic [LastStage:0]     vld_s;

	gaq_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_count (sample_count)
	);

	assign adv               = !pixel_out.valid || pixel_out.ready;
	assign pixel_in.ready    = adv;
	assign ctrl.advance      = adv;
	assign ctrl.sample_count = sample_count;

	assign lane_sum[LANE_RED]   = pixel_in.red_sum;
	assign lane_sum[LANE_GREEN] = pixel_in.green_sum;
	assign lane_sum[LANE_BLUE]  = pixel_in.blue_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LastStage-1:0], pixel_in.valid};
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		gaq_lane #(
			.SUM_WIDTH (SUM_WIDTH)
		) u_lane (
			.clk  (clk),
			.ctrl (ctrl),
			.sum  (lane_sum[g]),
			.res  (lane_res[g])
		);
	end

	gaq_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (adv),
		.lane_valid (vld_s[LastStage]),
		.lane_res   (lane_res),
		.pixel_out  (pixel_out)
	);

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_in.valid && pixel_in.ready |=> vld_s[0])
		else $error("accepted item did not enter the first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline moved while the output was stalled");

	a_last_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LastStage] && adv |=> pixel_out.valid)
		else $error("item in the last stage was not moved to the output");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !vld_s[LastStage] |=> !pixel_out.valid)
		else $error("output valid without an item from the last stage");

endmodule

`default_nettype wire
